FILE: sv/longest_isolated_diagonal_dp_unit_defines.svh
// ----------------------------------------------------------------------------
// Longest isolated diagonal unit: assertion macros
// Concurrent assertion shorthands clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LONGEST_ISOLATED_DIAGONAL_DP_UNIT_DEFINES_SVH
`define LONGEST_ISOLATED_DIAGONAL_DP_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LIDD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LIDD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lidd_pkg.sv
// ----------------------------------------------------------------------------
// Longest isolated diagonal unit: package
// Field widths, register indexes and default sizes shared by the design.
// ----------------------------------------------------------------------------
package lidd_pkg;

  localparam int CFG_W       = 13;
  localparam int OUT_W       = 13;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int IDX_W       = 1;

  localparam int DEF_MAX_COLS = 4096;
  localparam int DEF_MAX_ROWS = 4096;
  localparam int SIZE_RESET   = 4096;

  localparam logic [IDX_W-1:0] REG_COLS = 1'b0;
  localparam logic [IDX_W-1:0] REG_ROWS = 1'b1;

endpackage

FILE: sv/longest_isolated_diagonal_dp_unit.sv
// ----------------------------------------------------------------------------
// Longest isolated diagonal unit
// Finds the longest diagonal of ones framed by zeros in a streamed binary image.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the slave stream, one item per pixel, and
// one item carrying the frame's longest isolated diagonal leaves on the master
// stream after the last pixel of each frame. Each row is taken in full, then
// a right-to-left pass and a left-to-right pass of one column per cycle run
// through the single read port of the row stores, then the pipeline drains
// in the tail and settle states. The last row of a frame then loads the
// result register, which waits on m_axis_tready_i while it holds a result
// not yet taken. The input is not ready during the passes. No clearing pass
// is needed after reset, a size write or a frame end: the first row of a frame
// reads the per-column stores as zero. A size write restarts the frame.

`include "longest_isolated_diagonal_dp_unit_defines.svh"

module longest_isolated_diagonal_dp_unit
  import lidd_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // Pixel stream.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [0] pixel
  // Result stream.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // [12:0] longest_diagonal
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int MAXD = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int VW   = $clog2(MAXD + 1);
  localparam int COLS_RST = (SIZE_RESET > MAX_COLS) ? MAX_COLS : SIZE_RESET;
  localparam int ROWS_RST = (SIZE_RESET > MAX_ROWS) ? MAX_ROWS : SIZE_RESET;
  localparam int OUT_MAX  = (1 << OUT_W) - 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RTL    = 6'b000010,
    S_LTR    = 6'b000100,
    S_TAIL   = 6'b001000,
    S_SETTLE = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  function automatic logic [VW-1:0] min3(input logic [VW-1:0] a, input logic [VW-1:0] b,
                                         input logic [VW-1:0] c);
    logic [VW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  // Control state.
  state_e        state_q, state_d;
  logic [CW:0]   cols_q, cols_d;
  logic [RW:0]   rows_q, rows_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] j_q, j_d;
  logic          r_v_q, r_v_d;
  logic          l_v_q, l_v_d;
  logic          b_v_q, b_v_d;
  logic [VW-1:0] rz_run_q, rz_run_d;
  logic [VW-1:0] left_q, left_d;
  logic [VW-1:0] carry_q, carry_d;
  logic [VW-1:0] best_q, best_d;
  logic          m_valid_q, m_valid_d;
  logic          out_load;

  // Pipeline payload.
  logic [CW-1:0]    r_a_q;
  logic [CW-1:0]    l_a_q;
  logic             l_last_q;
  logic [VW-1:0]    nd_q, na_q;
  logic [OUT_W-1:0] m_data_q;

  // Row stores and their registered read data.
  logic          pix_mem [MAX_COLS];
  logic [VW-1:0] up_mem  [MAX_COLS];
  logic [VW-1:0] pd_mem  [MAX_COLS];
  logic [VW-1:0] pa_mem  [MAX_COLS];
  logic [VW-1:0] rzr_mem [MAX_COLS];
  logic          pix_rd_q;
  logic [VW-1:0] up_rd_q, pd_rd_q, pa_rd_q, rzr_rd_q;

  logic          in_acc;
  logic [CW-1:0] pix_ra;
  logic [CW-1:0] j_nx;
  logic          j_last;
  logic          first_row;
  logic [VW-1:0] rz_new;
  logic [VW-1:0] up_v, old_d, old_a, rz_v;
  logic [VW-1:0] nd, na, up_new;
  logic [VW-1:0] mx;
  logic [CW:0]   cfg_cols;
  logic [RW:0]   cfg_rows;
  logic [OUT_W-1:0] best_sat;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(m_data_q);

  assign pix_ra    = (state_q == S_RTL) ? k_q : j_q;
  assign j_nx      = CW'({1'b0, j_q} + (CW+1)'(1));
  assign j_last    = (({1'b0, j_q} + (CW+1)'(1)) == cols_q);
  assign first_row = (row_q == '0);

  // Right-to-left pass: zeros run from each column to the right.
  assign rz_new = pix_rd_q ? '0 : rz_run_q + VW'(1);

  // Left-to-right pass; the first row of a frame sees empty stores.
  always_comb begin
    up_v  = first_row ? '0 : up_rd_q;
    old_d = first_row ? '0 : pd_rd_q;
    old_a = (first_row || l_last_q) ? '0 : pa_rd_q;
    rz_v  = l_last_q ? '0 : rzr_rd_q;
    if (pix_rd_q) begin
      nd     = min3(carry_q, left_q, up_v) + VW'(1);
      na     = min3(old_a, up_v, rz_v) + VW'(1);
      up_new = '0;
    end else begin
      nd     = '0;
      na     = '0;
      up_new = up_v + VW'(1);
    end
  end

  assign mx = (nd_q > na_q) ? nd_q : na_q;

  always_comb begin
    if (32'(best_q) > OUT_MAX) begin
      best_sat = '1;
    end else begin
      best_sat = OUT_W'(best_q);
    end
  end

  // Out-of-range sizes are pulled into the supported range.
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_cols = (CW+1)'(1);
      cfg_rows = (RW+1)'(1);
    end else begin
      cfg_cols = (32'(cfg_data_i) > MAX_COLS) ? (CW+1)'(MAX_COLS) : (CW+1)'(cfg_data_i);
      cfg_rows = (32'(cfg_data_i) > MAX_ROWS) ? (RW+1)'(MAX_ROWS) : (RW+1)'(cfg_data_i);
    end
  end

  always_comb begin
    state_d   = state_q;
    cols_d    = cols_q;
    rows_d    = rows_q;
    col_d     = col_q;
    row_d     = row_q;
    k_d       = k_q;
    j_d       = j_q;
    r_v_d     = 1'b0;
    l_v_d     = 1'b0;
    b_v_d     = l_v_q;
    rz_run_d  = rz_run_q;
    left_d    = left_q;
    carry_d   = carry_q;
    best_d    = best_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    out_load  = 1'b0;

    if (r_v_q) begin
      rz_run_d = rz_new;
    end
    if (l_v_q) begin
      left_d  = pix_rd_q ? '0 : left_q + VW'(1);
      carry_d = old_d;
    end
    if (b_v_q && (mx > best_q)) begin
      best_d = mx;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (({1'b0, col_q} + (CW+1)'(1)) == cols_q) begin
            col_d    = '0;
            k_d      = CW'(cols_q - (CW+1)'(1));
            rz_run_d = '0;
            state_d  = S_RTL;
          end else begin
            col_d = col_q + CW'(1);
          end
        end
      end
      S_RTL: begin
        r_v_d = 1'b1;
        if (k_q == '0) begin
          j_d     = '0;
          left_d  = '0;
          carry_d = '0;
          state_d = S_LTR;
        end else begin
          k_d = k_q - CW'(1);
        end
      end
      S_LTR: begin
        l_v_d = 1'b1;
        if (j_last) begin
          state_d = S_TAIL;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      S_TAIL: begin
        state_d = S_SETTLE;
      end
      S_SETTLE: begin
        if (({1'b0, row_q} + (RW+1)'(1)) == rows_q) begin
          state_d = S_OUT;
        end else begin
          row_d   = row_q + RW'(1);
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          out_load  = 1'b1;
          best_d    = '0;
          row_d     = '0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A size write abandons the frame in progress.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COLS: cols_d = cfg_cols;
        REG_ROWS: rows_d = cfg_rows;
        default:  ;
      endcase
      state_d = S_IDLE;
      col_d   = '0;
      row_d   = '0;
      best_d  = '0;
      r_v_d   = 1'b0;
      l_v_d   = 1'b0;
      b_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cols_q    <= (CW+1)'(COLS_RST);
      rows_q    <= (RW+1)'(ROWS_RST);
      col_q     <= '0;
      row_q     <= '0;
      k_q       <= '0;
      j_q       <= '0;
      r_v_q     <= 1'b0;
      l_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      rz_run_q  <= '0;
      left_q    <= '0;
      carry_q   <= '0;
      best_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cols_q    <= cols_d;
      rows_q    <= rows_d;
      col_q     <= col_d;
      row_q     <= row_d;
      k_q       <= k_d;
      j_q       <= j_d;
      r_v_q     <= r_v_d;
      l_v_q     <= l_v_d;
      b_v_q     <= b_v_d;
      rz_run_q  <= rz_run_d;
      left_q    <= left_d;
      carry_q   <= carry_d;
      best_q    <= best_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_a_q    <= k_q;
    l_a_q    <= j_q;
    l_last_q <= j_last;
    nd_q     <= nd;
    na_q     <= na;
    if (out_load) begin
      m_data_q <= best_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_mem[col_q] <= s_axis_tdata_i[0];
    end
    pix_rd_q <= pix_mem[pix_ra];
  end

  always_ff @(posedge clk_i) begin
    if (r_v_q) begin
      rzr_mem[r_a_q] <= rz_new;
    end
    rzr_rd_q <= rzr_mem[j_nx];
  end

  always_ff @(posedge clk_i) begin
    if (l_v_q) begin
      up_mem[l_a_q] <= up_new;
    end
    up_rd_q <= up_mem[j_q];
  end

  always_ff @(posedge clk_i) begin
    if (l_v_q) begin
      pd_mem[l_a_q] <= nd;
    end
    pd_rd_q <= pd_mem[j_q];
  end

  always_ff @(posedge clk_i) begin
    if (l_v_q) begin
      pa_mem[l_a_q] <= na;
    end
    pa_rd_q <= pa_mem[j_nx];
  end

  `LIDD_ASSERT_IMP(a_ready_no_pass, s_axis_tready_o, !r_v_q && !l_v_q, "pass active while ready")
  `LIDD_ASSERT_IMP(a_passes_apart, r_v_q, !l_v_q, "both row passes active at once")
  `LIDD_ASSERT_IMP(a_col_in_range, 1'b1, {1'b0, col_q} < cols_q, "column beyond row size")
  `LIDD_ASSERT_NXT(a_cfg_restart, cfg_we_i, row_q == '0 && best_q == '0, "frame not restarted")

endmodule

FILE: tb/tb_longest_isolated_diagonal_dp_unit.sv
// ----------------------------------------------------------------------------
// Longest isolated diagonal unit: testbench
// Streams binary frames of many sizes into the unit and compares each frame
// result with a cycle-free model of the diagonal search kept in this bench.
// ----------------------------------------------------------------------------
module tb_longest_isolated_diagonal_dp_unit;
  import lidd_pkg::*;

  localparam int          MAX_COLS       = DEF_MAX_COLS;
  localparam int          MAX_ROWS       = DEF_MAX_ROWS;
  localparam int          IDLE_LIMIT     = 60000;
  localparam int unsigned RANDOM_ITEMS   = 280;
  localparam int unsigned RANDOM_FRAMES  = 20;

  // Frame fill styles.
  localparam int unsigned STYLE_RANDOM  = 0;
  localparam int unsigned STYLE_PLANTED = 1;
  localparam int unsigned STYLE_NOISY   = 2;

  typedef logic [OUT_W-1:0] count_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [IDX_W-1:0]       cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // [0] pixel
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // [12:0] longest_diagonal

  longest_isolated_diagonal_dp_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Model of the unit: size settings, row buffer and per-column stores.
  logic [CFG_W-1:0] cols_setting;
  logic [CFG_W-1:0] rows_setting;
  bit               row_buf     [MAX_COLS];
  count_t           diag_len    [MAX_COLS];
  count_t           anti_len    [MAX_COLS];
  count_t           zeros_above [MAX_COLS];
  count_t           zeros_right [MAX_COLS+1];
  int unsigned      col_pos;
  int unsigned      row_pos;
  count_t           best_len;
  count_t           expected_longest[$];

  int unsigned pixels_taken;
  int unsigned mismatches;
  int          idle_cycles;
  bit          gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic count_t min3(input count_t a, input count_t b, input count_t c);
    count_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic void clear_frame();
    for (int i = 0; i < MAX_COLS; i++) begin
      row_buf[i]     = 1'b0;
      diag_len[i]    = '0;
      anti_len[i]    = '0;
      zeros_above[i] = '0;
      zeros_right[i] = '0;
    end
    zeros_right[MAX_COLS] = '0;
    col_pos  = 0;
    row_pos  = 0;
    best_len = '0;
  endfunction

  // Row end: zero runs to the right first, then one sweep left to right that
  // extends both diagonal directions from the previous row.
  function automatic void close_row(input int unsigned cols);
    count_t left, carry, up, old_d, old_a, nd, na;
    left  = '0;
    carry = '0;
    zeros_right[cols] = '0;
    for (int unsigned j = cols; j > 0; j--)
      zeros_right[j-1] = row_buf[j-1] ? count_t'(0) : count_t'(zeros_right[j] + 1);
    for (int unsigned j = 0; j < cols; j++) begin
      up    = zeros_above[j];
      old_d = diag_len[j];
      old_a = (j + 1 < cols) ? anti_len[j+1] : count_t'(0);
      nd    = '0;
      na    = '0;
      if (row_buf[j]) begin
        nd = min3(carry + count_t'(1), left + count_t'(1), up + count_t'(1));
        na = min3(old_a + count_t'(1), up + count_t'(1), zeros_right[j+1] + count_t'(1));
        if (nd > best_len) best_len = nd;
        if (na > best_len) best_len = na;
        left           = '0;
        zeros_above[j] = '0;
      end else begin
        left           = left + count_t'(1);
        zeros_above[j] = up + count_t'(1);
      end
      carry       = old_d;
      diag_len[j] = nd;
      anti_len[j] = na;
    end
  endfunction

  function automatic void track_pixel(input bit p);
    int unsigned cols, rows;
    cols = eff_size(cols_setting, MAX_COLS);
    rows = eff_size(rows_setting, MAX_ROWS);
    if (col_pos >= cols) col_pos = 0;
    row_buf[col_pos] = p;
    col_pos++;
    if (col_pos < cols) return;
    close_row(cols);
    col_pos = 0;
    row_pos++;
    if (row_pos < rows) return;
    expected_longest.push_back(best_len);
    clear_frame();
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // All sampling happens here at the rising edge; inputs only move at the
  // falling edge, so the values seen are the ones of the handshake.
  always @(posedge clk_i) begin : monitor
    bit moved;
    count_t want;
    if (!rst_ni) begin
      cols_setting = SIZE_RESET;
      rows_setting = SIZE_RESET;
      clear_frame();
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_COLS) cols_setting = cfg_data_i;
        else if (cfg_idx_i == REG_ROWS) rows_setting = cfg_data_i;
        clear_frame();
        moved = 1'b1;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        track_pixel(s_axis_tdata_i[0]);
        pixels_taken++;
        moved = 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        moved = 1'b1;
        if (expected_longest.size() == 0) begin
          report_mismatch($sformatf("result %0d with no frame pending", m_axis_tdata_o));
        end else begin
          want = expected_longest.pop_front();
          if (m_axis_tdata_o !== {{(OUT_TDATA_W-OUT_W){1'b0}}, want})
            report_mismatch($sformatf("longest_diagonal got %0d expected %0d",
                                      m_axis_tdata_o, want));
        end
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        stall_left = gaps_on ? pick_gap() : 0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item
  // was taken, with tvalid still high so a back-to-back item can follow.
  task automatic send_pixel(input bit p);
    int gap;
    int unsigned seen;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W-1){1'b0}}, p};
    seen = pixels_taken;
    do @(negedge clk_i); while (pixels_taken == seen);
  endtask

  task automatic wait_results();
    s_axis_tvalid_i <= 1'b0;
    while (expected_longest.size() != 0) @(negedge clk_i);
  endtask

  // A frame that stops short gives no result, so the row passes may still be
  // running; let them finish before touching a size register.
  task automatic write_size(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    wait_results();
    repeat (3 * eff_size(cols_setting, MAX_COLS) + 20) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic send_pattern(input logic [15:0] bits, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_pixel(bits[i]);
  endtask

  // Random fill, a clean planted diagonal, or a planted diagonal with a few
  // flipped pixels. A len of 0 picks one.
  task automatic send_frame(input int unsigned cols, input int unsigned rows,
                            input int unsigned count, input int unsigned style,
                            input int unsigned len);
    int unsigned density, dir, r0, c0, r, c, span;
    bit on, p;
    span    = (cols < rows) ? cols : rows;
    if (len == 0) len = $urandom_range(1, span);
    density = $urandom_range(1, 7);
    dir     = $urandom_range(0, 1);
    r0      = $urandom_range(0, rows - len);
    c0      = $urandom_range(0, cols - len);
    for (int unsigned n = 0; n < count; n++) begin
      r  = n / cols;
      c  = n % cols;
      on = (r >= r0) && (r < r0 + len) &&
           (dir ? (c == c0 + len - 1 - (r - r0)) : (c == c0 + (r - r0)));
      case (style)
        STYLE_RANDOM: begin
          p = ($urandom_range(0, 7) < density);
        end
        STYLE_PLANTED: begin
          p = on;
        end
        default: begin
          p = on ^ ($urandom_range(0, 15) == 0);
        end
      endcase
      send_pixel(p);
    end
  endtask

  task automatic test_directed_shapes();
    gaps_on = 1'b1;
    write_size(REG_COLS, 3);
    write_size(REG_ROWS, 3);
    send_pattern(16'b100010001, 9);   // main diagonal
    send_pattern(16'b001010100, 9);   // anti-diagonal
    write_size(REG_COLS, 1);
    write_size(REG_ROWS, 1);
    send_pattern(16'b1, 1);
    send_pattern(16'b0, 1);
    // A size write in the middle of a frame drops that frame.
    write_size(REG_COLS, 2);
    write_size(REG_ROWS, 2);
    send_pattern(16'b001, 3);
    write_size(REG_COLS, 2);
    send_pattern(16'b1111, 4);
    wait_results();
  endtask

  task automatic test_large_diagonal();
    gaps_on = 1'b1;
    write_size(REG_COLS, 8);
    write_size(REG_ROWS, 8);
    send_frame(8, 8, 8 * 8, STYLE_PLANTED, 8);
    wait_results();
  endtask

  task automatic test_size_extremes();
    gaps_on = 1'b1;
    // Zero acts as one and anything above the maximum acts as the maximum.
    write_size(REG_COLS, 0);
    write_size(REG_ROWS, 5);
    send_frame(1, 5, 5, STYLE_NOISY, 0);
    // With the row count at its maximum, a short run of rows gives no result.
    write_size(REG_ROWS, 8191);
    send_frame(1, 4096, 30, STYLE_RANDOM, 0);
    // With the row length at its maximum, a short run of pixels ends no row.
    write_size(REG_COLS, 8191);
    write_size(REG_ROWS, 0);
    send_frame(4096, 1, 20, STYLE_RANDOM, 0);
    wait_results();
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    return ($urandom_range(0, 19) == 0) ? CFG_W'(0) : CFG_W'($urandom_range(1, 6));
  endfunction

  task automatic test_random_frames();
    int unsigned sent, frames, cols, rows, count, which;
    bit must_write;
    sent       = 0;
    frames     = 0;
    must_write = 1'b1;
    while (sent < RANDOM_ITEMS || frames < RANDOM_FRAMES) begin
      if (must_write || $urandom_range(0, 3) == 0) begin
        which = $urandom_range(0, 2);
        if (which != 2) write_size(REG_COLS, pick_size());
        if (which != 1) write_size(REG_ROWS, pick_size());
        must_write = 1'b0;
      end
      cols    = eff_size(cols_setting, MAX_COLS);
      rows    = eff_size(rows_setting, MAX_ROWS);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (cols * rows > 1 && $urandom_range(0, 9) == 0) begin
        count      = $urandom_range(1, cols * rows - 1);
        must_write = 1'b1;
      end else begin
        count = cols * rows;
        frames++;
      end
      send_frame(cols, rows, count, $urandom_range(STYLE_RANDOM, STYLE_NOISY), 0);
      sent += count;
      if ($urandom_range(0, 4) == 0) wait_results();
    end
    wait_results();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_COLS;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    pixels_taken    = 0;
    mismatches      = 0;
    gaps_on         = 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_shapes();
    test_large_diagonal();
    test_size_extremes();
    test_random_frames();

    repeat (3 * eff_size(cols_setting, MAX_COLS) + 20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
